// File: hdl/cmq_pkg.sv
// Shared constants and types for the cubic misorientation pipeline.
// No dependencies; the files that use it refer to this package by scoped names.
package cmq_pkg;

   localparam int COMP_BITS_DEF = 16;
   localparam int CORDIC_STEPS  = 30;
   localparam int Z_W           = 33;   // signed Q.30 angle accumulator
   localparam int NORM_W        = 24;   // axis components normalized below 2^24
   localparam int QUOT_W        = 16;
   localparam int FIELD_W       = 16;

   localparam logic [30:0] INV_SQRT2_Q31 = 31'h5A82799A;
   localparam logic [15:0] AXIS_ONE      = 16'h7FFF;

   localparam logic [0:CORDIC_STEPS-1][31:0] ATAN_Q30 = {
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
      32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
      32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
      32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
      32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
      32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
   };

   typedef enum logic [1:0] {
      SYM_FACE   = 2'd0,
      SYM_EDGE   = 2'd1,
      SYM_CORNER = 2'd2
   } sym_type_type;

endpackage

// File: hdl/cubic_misorientation_quat.sv
// Top level of the cubic misorientation unit: quaternion pair in, angle and axis out.
// Depends on cmq_pkg, cmq_front, cmq_sqrt_pipe, cmq_cordic and cmq_div_pipe.
//
//   channel   | ports                                   | handshake
//   ----------+-----------------------------------------+---------------------------
//   request   | req_a_x..req_a_w, req_b_x..req_b_w      | start high, busy low
//   response  | rsp_angle, rsp_axis_x/_y/_z             | rsp_strobe, one cycle
//
// One transaction enters every cycle; busy is held low. The pipe holds 6 front
// stages, COMP_BITS + 1 square-root stages for sin, 30 CORDIC stages, 5 axis
// stages, 25 square-root stages for the axis length, 16 divider stages and
// the output register.
// Reset (synchronous) clears only the valid bits; transactions in flight are dropped.
// The receiver cannot stall, so nothing in the pipe ever holds.
module cubic_misorientation_quat #(
   parameter int COMP_BITS = cmq_pkg::COMP_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_a_x,
   input  logic signed [15:0] req_a_y,
   input  logic signed [15:0] req_a_z,
   input  logic signed [15:0] req_a_w,
   input  logic signed [15:0] req_b_x,
   input  logic signed [15:0] req_b_y,
   input  logic signed [15:0] req_b_z,
   input  logic signed [15:0] req_b_w,
   output logic               rsp_strobe,
   output logic [15:0]        rsp_angle,
   output logic signed [15:0] rsp_axis_x,
   output logic signed [15:0] rsp_axis_y,
   output logic signed [15:0] rsp_axis_z
);
   localparam int PW   = COMP_BITS + 1;
   localparam int VW   = COMP_BITS + 3;
   localparam int MW   = COMP_BITS + 2;
   localparam int NW   = 2 * COMP_BITS + 1;
   localparam int XW   = COMP_BITS + 4;
   localparam int ZW   = cmq_pkg::Z_W;
   localparam int NRW  = cmq_pkg::NORM_W;
   localparam int SQW  = 2 * NRW + 2;
   localparam int LW   = (SQW + 1) / 2;
   localparam int QW   = cmq_pkg::QUOT_W;
   localparam int DNW  = NRW + QW;
   localparam int PSW  = $clog2(MW);
   localparam int SB1  = PW + 3 * VW;
   localparam int SB2  = 1 + 3 * VW;
   localparam int SB3  = 16 + 3 + 3 * NRW + 1;
   localparam int SB4  = 16 + 1 + 1;

   // never stalls
   assign busy = 1'b0;

   // front end
   logic               f_vld;
   logic [PW-1:0]      f_c;
   logic [2:0][VW-1:0] f_v;
   logic [NW-1:0]      f_nsq;

   cmq_front #(.COMP_BITS(COMP_BITS)) u_front (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (start & ~busy),
      .a_x     (req_a_x),
      .a_y     (req_a_y),
      .a_z     (req_a_z),
      .a_w     (req_a_w),
      .b_x     (req_b_x),
      .b_y     (req_b_y),
      .b_z     (req_b_z),
      .b_w     (req_b_w),
      .out_vld (f_vld),
      .out_c   (f_c),
      .out_v   (f_v),
      .out_nsq (f_nsq)
   );

   // sin of the half angle
   logic           s_vld;
   logic [PW-1:0]  s_root;
   logic [SB1-1:0] s_sb;

   cmq_sqrt_pipe #(.IN_W(NW), .SB_W(SB1)) u_sin_sqrt (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (f_vld),
      .in_rad   (f_nsq),
      .in_sb    ({f_c, f_v}),
      .out_vld  (s_vld),
      .out_root (s_root),
      .out_sb   (s_sb)
   );

   // half angle = atan2(s, c); carry the zero-angle flag and the axis vector
   logic                 k_vld;
   logic signed [ZW-1:0] k_z;
   logic [SB2-1:0]       k_sb;

   cmq_cordic #(.XW(XW), .SB_W(SB2)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (s_vld),
      .in_x    ($signed(XW'(s_sb[SB1-1 -: PW]))),
      .in_y    ($signed(XW'(s_root))),
      .in_sb   ({(s_root == '0), s_sb[3*VW-1:0]}),
      .out_vld (k_vld),
      .out_z   (k_z),
      .out_sb  (k_sb)
   );

   // A1: round the angle, take axis magnitudes and their maximum
   logic                 k_zero;
   logic [31:0]          z_pos;
   logic [32:0]          z_rnd;
   logic [15:0]          angle_in;
   logic signed [VW-1:0] kv [3];
   logic [MW-1:0]        kmag [3];
   logic [MW-1:0]        kmax;

   logic          a1_vld_ff;
   logic [15:0]   a1_angle_ff;
   logic [2:0]    a1_sgn_ff;
   logic [MW-1:0] a1_mag_ff [3];
   logic [MW-1:0] a1_max_ff;
   logic          a1_zf_ff;

   always_comb begin
      k_zero = k_sb[SB2-1];
      z_pos  = (k_zero || k_z < 0) ? '0 : k_z[31:0];
      z_rnd  = {1'b0, z_pos} + 33'(1 << 14);
      // saturate the rounded angle to 16 bits
      angle_in = (z_rnd[32:31] != 2'b00) ? 16'hFFFF : z_rnd[30:15];
      kmax = '0;
      for (int i = 0; i < 3; i++) begin
         kv[i]   = $signed(k_sb[i*VW +: VW]);
         kmag[i] = kv[i][VW-1] ? MW'(-kv[i]) : MW'(kv[i]);
         if (kmag[i] > kmax) begin
            kmax = kmag[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a1_vld_ff <= 1'b0;
      end else begin
         a1_vld_ff <= k_vld;
      end
      a1_angle_ff <= angle_in;
      for (int i = 0; i < 3; i++) begin
         a1_sgn_ff[i] <= kv[i][VW-1];
         a1_mag_ff[i] <= kmag[i];
      end
      a1_max_ff <= kmax;
      // zero angle or zero axis vector: fall back to the z axis
      a1_zf_ff  <= k_zero | (kmax == '0);
   end

   // A2: find the leading one of the largest magnitude
   logic [PSW-1:0] lead;

   logic           a2_vld_ff;
   logic [15:0]    a2_angle_ff;
   logic [2:0]     a2_sgn_ff;
   logic [MW-1:0]  a2_mag_ff [3];
   logic [PSW-1:0] a2_pos_ff;
   logic           a2_zf_ff;

   always_comb begin
      lead = '0;
      for (int i = 0; i < MW; i++) begin
         if (a1_max_ff[i]) begin
            lead = PSW'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a2_vld_ff <= 1'b0;
      end else begin
         a2_vld_ff <= a1_vld_ff;
      end
      a2_angle_ff <= a1_angle_ff;
      a2_sgn_ff   <= a1_sgn_ff;
      a2_mag_ff   <= a1_mag_ff;
      a2_pos_ff   <= lead;
      a2_zf_ff    <= a1_zf_ff;
   end

   // A3: shift so the largest magnitude lands in [2^23, 2^24), truncating
   logic [MW+NRW-2:0] shf [3];

   logic           a3_vld_ff;
   logic [15:0]    a3_angle_ff;
   logic [2:0]     a3_sgn_ff;
   logic [NRW-1:0] a3_nrm_ff [3];
   logic           a3_zf_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         shf[i] = {a2_mag_ff[i], (NRW-1)'(0)} >> a2_pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a3_vld_ff <= 1'b0;
      end else begin
         a3_vld_ff <= a2_vld_ff;
      end
      a3_angle_ff <= a2_angle_ff;
      a3_sgn_ff   <= a2_sgn_ff;
      for (int i = 0; i < 3; i++) begin
         a3_nrm_ff[i] <= shf[i][NRW-1:0];
      end
      a3_zf_ff <= a2_zf_ff;
   end

   // A4: squares
   logic             a4_vld_ff;
   logic [15:0]      a4_angle_ff;
   logic [2:0]       a4_sgn_ff;
   logic [NRW-1:0]   a4_nrm_ff [3];
   logic [2*NRW-1:0] a4_sq_ff [3];
   logic             a4_zf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a4_vld_ff <= 1'b0;
      end else begin
         a4_vld_ff <= a3_vld_ff;
      end
      a4_angle_ff <= a3_angle_ff;
      a4_sgn_ff   <= a3_sgn_ff;
      for (int i = 0; i < 3; i++) begin
         a4_nrm_ff[i] <= a3_nrm_ff[i];
         a4_sq_ff[i]  <= (2*NRW)'(a3_nrm_ff[i]) * (2*NRW)'(a3_nrm_ff[i]);
      end
      a4_zf_ff <= a3_zf_ff;
   end

   // A5: sum of squares
   logic           a5_vld_ff;
   logic [SB3-1:0] a5_sb_ff;
   logic [SQW-1:0] a5_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a5_vld_ff <= 1'b0;
      end else begin
         a5_vld_ff <= a4_vld_ff;
      end
      a5_sum_ff <= SQW'(a4_sq_ff[0]) + SQW'(a4_sq_ff[1]) + SQW'(a4_sq_ff[2]);
      a5_sb_ff  <= {a4_angle_ff, a4_sgn_ff, a4_nrm_ff[2], a4_nrm_ff[1],
                    a4_nrm_ff[0], a4_zf_ff};
   end

   // axis length
   logic           l_vld;
   logic [LW-1:0]  l_len;
   logic [SB3-1:0] l_sb;

   cmq_sqrt_pipe #(.IN_W(SQW), .SB_W(SB3)) u_len_sqrt (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (a5_vld_ff),
      .in_rad   (a5_sum_ff),
      .in_sb    (a5_sb_ff),
      .out_vld  (l_vld),
      .out_root (l_len),
      .out_sb   (l_sb)
   );

   // per-lane rounded quotient |v| * 2^15 / L
   logic           l_zf;
   logic [2:0]     l_sgn;
   logic [15:0]    l_angle;
   logic [DNW-1:0] num [3];
   logic [2:0]     d_vld;
   logic [QW-1:0]  d_quo [3];
   logic [SB4-1:0] d_sb0;
   logic           d_sgn1;
   logic           d_sgn2;

   always_comb begin
      l_zf    = l_sb[0];
      l_angle = l_sb[SB3-1 -: 16];
      l_sgn   = l_sb[SB3-17 -: 3];
      for (int i = 0; i < 3; i++) begin
         num[i] = DNW'({l_sb[1 + i*NRW +: NRW], (QW-1)'(0)}) + DNW'(l_len >> 1);
      end
   end

   cmq_div_pipe #(.N_W(DNW), .D_W(LW), .Q_W(QW), .SB_W(SB4)) u_div_x (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (l_vld),
      .in_num  (num[0]),
      .in_den  (l_len),
      .in_sb   ({l_angle, l_zf, l_sgn[0]}),
      .out_vld (d_vld[0]),
      .out_quo (d_quo[0]),
      .out_sb  (d_sb0)
   );

   cmq_div_pipe #(.N_W(DNW), .D_W(LW), .Q_W(QW), .SB_W(1)) u_div_y (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (l_vld),
      .in_num  (num[1]),
      .in_den  (l_len),
      .in_sb   (l_sgn[1]),
      .out_vld (d_vld[1]),
      .out_quo (d_quo[1]),
      .out_sb  (d_sgn1)
   );

   cmq_div_pipe #(.N_W(DNW), .D_W(LW), .Q_W(QW), .SB_W(1)) u_div_z (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (l_vld),
      .in_num  (num[2]),
      .in_den  (l_len),
      .in_sb   (l_sgn[2]),
      .out_vld (d_vld[2]),
      .out_quo (d_quo[2]),
      .out_sb  (d_sgn2)
   );

   // output register: saturate, restore sign, apply the z-axis fallback
   logic [2:0]  o_sgn;
   logic [14:0] o_sat [3];
   logic [15:0] o_cmp [3];
   logic        o_zf;

   logic        strobe_ff;
   logic [15:0] angle_ff;
   logic [15:0] ax_ff [3];

   always_comb begin
      o_sgn = {d_sgn2, d_sgn1, d_sb0[0]};
      o_zf  = d_sb0[1];
      for (int i = 0; i < 3; i++) begin
         o_sat[i] = d_quo[i][15] ? 15'h7FFF : d_quo[i][14:0];
         o_cmp[i] = o_sgn[i] ? 16'(-{1'b0, o_sat[i]}) : {1'b0, o_sat[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= &d_vld;
      end
      angle_ff <= d_sb0[SB4-1 -: 16];
      if (o_zf) begin
         ax_ff[0] <= '0;
         ax_ff[1] <= '0;
         ax_ff[2] <= cmq_pkg::AXIS_ONE;
      end else begin
         ax_ff[0] <= o_cmp[0];
         ax_ff[1] <= o_cmp[1];
         ax_ff[2] <= o_cmp[2];
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_angle  = angle_ff;
   assign rsp_axis_x = $signed(ax_ff[0]);
   assign rsp_axis_y = $signed(ax_ff[1]);
   assign rsp_axis_z = $signed(ax_ff[2]);

endmodule

// File: hdl/cmq_sqrt_pipe.sv
// Pipelined floor square root, one result bit per register stage.
// Carries a sideband word alongside; uses no package items.
module cmq_sqrt_pipe #(
   parameter int IN_W = 33,
   parameter int SB_W = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_vld,
   input  logic [IN_W-1:0]         in_rad,
   input  logic [SB_W-1:0]         in_sb,
   output logic                    out_vld,
   output logic [(IN_W+1)/2-1:0]   out_root,
   output logic [SB_W-1:0]         out_sb
);
   localparam int NS  = (IN_W + 1) / 2;
   localparam int PW  = 2 * NS;
   localparam int RMW = NS + 2;

   logic            vld_ff  [NS];
   logic [PW-1:0]   rad_ff  [NS];
   logic [NS-1:0]   root_ff [NS];
   logic [RMW-1:0]  rem_ff  [NS];
   logic [SB_W-1:0] sb_ff   [NS];

   for (genvar k = 0; k < NS; k++) begin : g_stage
      logic            vld_src;
      logic [PW-1:0]   rad_src;
      logic [NS-1:0]   root_src;
      logic [RMW-1:0]  rem_src;
      logic [SB_W-1:0] sb_src;
      logic [RMW-1:0]  rem_shf;
      logic [RMW-1:0]  trial;
      logic [PW-1:0]   rad_in;
      logic [NS-1:0]   root_in;
      logic [RMW-1:0]  rem_in;

      if (k == 0) begin : g_first
         assign vld_src  = in_vld;
         assign rad_src  = PW'(in_rad);
         assign root_src = '0;
         assign rem_src  = '0;
         assign sb_src   = in_sb;
      end else begin : g_next
         assign vld_src  = vld_ff[k-1];
         assign rad_src  = rad_ff[k-1];
         assign root_src = root_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign sb_src   = sb_ff[k-1];
      end

      always_comb begin
         rem_shf = {rem_src[RMW-3:0], rad_src[PW-1 -: 2]};
         trial   = {root_src, 2'b01};
         rad_in  = {rad_src[PW-3:0], 2'b00};
         if (rem_shf >= trial) begin
            rem_in  = rem_shf - trial;
            root_in = {root_src[NS-2:0], 1'b1};
         end else begin
            rem_in  = rem_shf;
            root_in = {root_src[NS-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_src;
         end
         rad_ff[k]  <= rad_in;
         root_ff[k] <= root_in;
         rem_ff[k]  <= rem_in;
         sb_ff[k]   <= sb_src;
      end
   end

   assign out_vld  = vld_ff[NS-1];
   assign out_root = root_ff[NS-1];
   assign out_sb   = sb_ff[NS-1];

endmodule

// File: hdl/cmq_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Needs num < den * 2^Q_W; uses no package items.
module cmq_div_pipe #(
   parameter int N_W  = 40,
   parameter int D_W  = 25,
   parameter int Q_W  = 16,
   parameter int SB_W = 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_vld,
   input  logic [N_W-1:0]  in_num,
   input  logic [D_W-1:0]  in_den,
   input  logic [SB_W-1:0] in_sb,
   output logic            out_vld,
   output logic [Q_W-1:0]  out_quo,
   output logic [SB_W-1:0] out_sb
);
   logic            vld_ff [Q_W];
   logic [D_W-1:0]  rem_ff [Q_W];
   logic [Q_W-1:0]  low_ff [Q_W];
   logic [Q_W-1:0]  quo_ff [Q_W];
   logic [D_W-1:0]  den_ff [Q_W];
   logic [SB_W-1:0] sb_ff  [Q_W];

   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      logic            vld_src;
      logic [D_W-1:0]  rem_src;
      logic [Q_W-1:0]  low_src;
      logic [Q_W-1:0]  quo_src;
      logic [D_W-1:0]  den_src;
      logic [SB_W-1:0] sb_src;
      logic [D_W:0]    rem_shf;
      logic [D_W-1:0]  rem_in;
      logic [Q_W-1:0]  quo_in;

      if (k == 0) begin : g_first
         assign vld_src = in_vld;
         assign rem_src = D_W'(in_num[N_W-1:Q_W]);
         assign low_src = in_num[Q_W-1:0];
         assign quo_src = '0;
         assign den_src = in_den;
         assign sb_src  = in_sb;
      end else begin : g_next
         assign vld_src = vld_ff[k-1];
         assign rem_src = rem_ff[k-1];
         assign low_src = low_ff[k-1];
         assign quo_src = quo_ff[k-1];
         assign den_src = den_ff[k-1];
         assign sb_src  = sb_ff[k-1];
      end

      always_comb begin
         rem_shf = {rem_src, low_src[Q_W-1]};
         if (rem_shf >= {1'b0, den_src}) begin
            rem_in = D_W'(rem_shf - {1'b0, den_src});
            quo_in = {quo_src[Q_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shf[D_W-1:0];
            quo_in = {quo_src[Q_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_src;
         end
         rem_ff[k] <= rem_in;
         low_ff[k] <= {low_src[Q_W-2:0], 1'b0};
         quo_ff[k] <= quo_in;
         den_ff[k] <= den_src;
         sb_ff[k]  <= sb_src;
      end
   end

   assign out_vld = vld_ff[Q_W-1];
   assign out_quo = quo_ff[Q_W-1];
   assign out_sb  = sb_ff[Q_W-1];

endmodule

// File: hdl/cmq_cordic.sv
// Vectoring CORDIC, one micro-rotation per register stage, giving atan2(y, x).
// Depends on cmq_pkg for the arctangent table, step count and angle width.
module cmq_cordic #(
   parameter int XW   = 20,
   parameter int SB_W = 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_vld,
   input  logic signed [XW-1:0]         in_x,
   input  logic signed [XW-1:0]         in_y,
   input  logic [SB_W-1:0]              in_sb,
   output logic                         out_vld,
   output logic signed [cmq_pkg::Z_W-1:0] out_z,
   output logic [SB_W-1:0]              out_sb
);
   localparam int NS = cmq_pkg::CORDIC_STEPS;
   localparam int ZW = cmq_pkg::Z_W;

   logic                 vld_ff [NS];
   logic signed [XW-1:0] x_ff   [NS];
   logic signed [XW-1:0] y_ff   [NS];
   logic signed [ZW-1:0] z_ff   [NS];
   logic [SB_W-1:0]      sb_ff  [NS];

   for (genvar k = 0; k < NS; k++) begin : g_stage
      logic                 vld_src;
      logic signed [XW-1:0] x_src;
      logic signed [XW-1:0] y_src;
      logic signed [ZW-1:0] z_src;
      logic [SB_W-1:0]      sb_src;
      logic signed [XW-1:0] dx;
      logic signed [XW-1:0] dy;
      logic signed [ZW-1:0] step;
      logic signed [XW-1:0] x_in;
      logic signed [XW-1:0] y_in;
      logic signed [ZW-1:0] z_in;

      if (k == 0) begin : g_first
         assign vld_src = in_vld;
         assign x_src   = in_x;
         assign y_src   = in_y;
         assign z_src   = '0;
         assign sb_src  = in_sb;
      end else begin : g_next
         assign vld_src = vld_ff[k-1];
         assign x_src   = x_ff[k-1];
         assign y_src   = y_ff[k-1];
         assign z_src   = z_ff[k-1];
         assign sb_src  = sb_ff[k-1];
      end

      always_comb begin
         dx   = x_src >>> k;
         dy   = y_src >>> k;
         step = $signed(ZW'(cmq_pkg::ATAN_Q30[k]));
         if (y_src > 0) begin
            x_in = x_src + dy;
            y_in = y_src - dx;
            z_in = z_src + step;
         end else begin
            x_in = x_src - dy;
            y_in = y_src + dx;
            z_in = z_src - step;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_src;
         end
         x_ff[k]  <= x_in;
         y_ff[k]  <= y_in;
         z_ff[k]  <= z_in;
         sb_ff[k] <= sb_src;
      end
   end

   assign out_vld = vld_ff[NS-1];
   assign out_z   = z_ff[NS-1];
   assign out_sb  = sb_ff[NS-1];

endmodule

// File: hdl/cmq_front.sv
// Front end: relative quaternion, magnitudes, sort, symmetry pick, axis vector
// and 1 - c^2. Six register stages. Depends on cmq_pkg.
module cmq_front #(
   parameter int COMP_BITS = cmq_pkg::COMP_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_vld,
   input  logic signed [15:0]          a_x,
   input  logic signed [15:0]          a_y,
   input  logic signed [15:0]          a_z,
   input  logic signed [15:0]          a_w,
   input  logic signed [15:0]          b_x,
   input  logic signed [15:0]          b_y,
   input  logic signed [15:0]          b_z,
   input  logic signed [15:0]          b_w,
   output logic                        out_vld,
   output logic [COMP_BITS:0]          out_c,
   output logic [2:0][COMP_BITS+2:0]   out_v,
   output logic [2*COMP_BITS:0]        out_nsq
);
   localparam int PW  = COMP_BITS + 1;
   localparam int CW  = COMP_BITS + 2;
   localparam int VW  = COMP_BITS + 3;
   localparam int NW  = 2 * COMP_BITS + 1;
   localparam int MXW = 36;
   localparam int SH  = 30 - COMP_BITS;
   localparam logic [MXW-1:0] ONE_X = MXW'(1) << COMP_BITS;
   localparam logic [PW-1:0]  ONE_P = PW'(1) << COMP_BITS;

   logic [5:0] vld_ff;

   // products
   logic signed [15:0] opa [16];
   logic signed [15:0] opb [16];
   logic signed [31:0] prod_ff [16];

   always_comb begin
      opa[0]  = a_x; opb[0]  = b_w;  opa[1]  = a_w; opb[1]  = b_x;
      opa[2]  = a_y; opb[2]  = b_z;  opa[3]  = a_z; opb[3]  = b_y;
      opa[4]  = a_y; opb[4]  = b_w;  opa[5]  = a_w; opb[5]  = b_y;
      opa[6]  = a_z; opb[6]  = b_x;  opa[7]  = a_x; opb[7]  = b_z;
      opa[8]  = a_z; opb[8]  = b_w;  opa[9]  = a_w; opb[9]  = b_z;
      opa[10] = a_x; opb[10] = b_y;  opa[11] = a_y; opb[11] = b_x;
      opa[12] = a_w; opb[12] = b_w;  opa[13] = a_x; opb[13] = b_x;
      opa[14] = a_y; opb[14] = b_y;  opa[15] = a_z; opb[15] = b_z;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 16; i++) begin
         prod_ff[i] <= opa[i] * opb[i];
      end
   end

   // sums and magnitudes
   logic signed [33:0] rsum [4];
   logic [MXW-1:0]     mx   [4];
   logic [MXW-1:0]     sc   [4];
   logic [PW-1:0]      mag_ff [4];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         if (k < 3) begin
            rsum[k] = -34'(prod_ff[4*k]) + 34'(prod_ff[4*k+1])
                      - 34'(prod_ff[4*k+2]) + 34'(prod_ff[4*k+3]);
         end else begin
            rsum[k] = -34'(prod_ff[4*k]) - 34'(prod_ff[4*k+1])
                      - 34'(prod_ff[4*k+2]) - 34'(prod_ff[4*k+3]);
         end
         mx[k] = rsum[k][33] ? MXW'(-rsum[k]) : MXW'(rsum[k]);
      end
   end

   if (SH > 0) begin : g_round
      always_comb begin
         for (int k = 0; k < 4; k++) begin
            sc[k] = (mx[k] + (MXW'(1) << (SH - 1))) >> SH;
         end
      end
   end else if (SH == 0) begin : g_keep
      always_comb begin
         for (int k = 0; k < 4; k++) begin
            sc[k] = mx[k];
         end
      end
   end else begin : g_widen
      always_comb begin
         for (int k = 0; k < 4; k++) begin
            sc[k] = mx[k] << (-SH);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         mag_ff[k] <= (sc[k] > ONE_X) ? ONE_P : sc[k][PW-1:0];
      end
   end

   // four-input sorting network, ascending
   logic [PW-1:0] l1 [4];
   logic [PW-1:0] l2 [4];
   logic [PW-1:0] srt_ff [4];

   always_comb begin
      l1[0] = (mag_ff[0] > mag_ff[1]) ? mag_ff[1] : mag_ff[0];
      l1[1] = (mag_ff[0] > mag_ff[1]) ? mag_ff[0] : mag_ff[1];
      l1[2] = (mag_ff[2] > mag_ff[3]) ? mag_ff[3] : mag_ff[2];
      l1[3] = (mag_ff[2] > mag_ff[3]) ? mag_ff[2] : mag_ff[3];
      l2[0] = (l1[0] > l1[2]) ? l1[2] : l1[0];
      l2[2] = (l1[0] > l1[2]) ? l1[0] : l1[2];
      l2[1] = (l1[1] > l1[3]) ? l1[3] : l1[1];
      l2[3] = (l1[1] > l1[3]) ? l1[1] : l1[3];
   end

   always_ff @(posedge clock) begin
      srt_ff[0] <= l2[0];
      srt_ff[1] <= (l2[1] > l2[2]) ? l2[2] : l2[1];
      srt_ff[2] <= (l2[1] > l2[2]) ? l2[1] : l2[2];
      srt_ff[3] <= l2[3];
   end

   // symmetry candidates
   logic [CW-1:0]    pair;
   logic [CW+30:0]   pair_prod;
   logic [CW:0]      quad;
   logic [CW-1:0]    cand2_ff;
   logic [CW-1:0]    cand3_ff;
   logic [PW-1:0]    p_ff [4];

   always_comb begin
      pair      = CW'(srt_ff[2]) + CW'(srt_ff[3]);
      pair_prod = (CW+31)'(pair) * (CW+31)'(cmq_pkg::INV_SQRT2_Q31);
      quad      = (CW+1)'(srt_ff[0]) + (CW+1)'(srt_ff[1])
                  + (CW+1)'(srt_ff[2]) + (CW+1)'(srt_ff[3]);
   end

   always_ff @(posedge clock) begin
      cand2_ff <= pair_prod[CW+30:31];
      cand3_ff <= quad[CW:1];
      for (int k = 0; k < 4; k++) begin
         p_ff[k] <= srt_ff[k];
      end
   end

   // pick the symmetry type, clamp c, build the axis vector
   cmq_pkg::sym_type_type sym;
   logic [CW-1:0]        cbest;
   logic signed [VW-1:0] q1, q2, q3, q4;
   logic signed [VW-1:0] vec [3];
   logic [PW-1:0]        c_ff;
   logic [2:0][VW-1:0]   v_ff;

   always_comb begin
      cbest = CW'(p_ff[3]);
      sym   = cmq_pkg::SYM_FACE;
      if (cand2_ff > cbest) begin
         cbest = cand2_ff;
         sym   = cmq_pkg::SYM_EDGE;
      end
      if (cand3_ff > cbest) begin
         cbest = cand3_ff;
         sym   = cmq_pkg::SYM_CORNER;
      end
      q1 = $signed({2'b00, p_ff[0]});
      q2 = $signed({2'b00, p_ff[1]});
      q3 = $signed({2'b00, p_ff[2]});
      q4 = $signed({2'b00, p_ff[3]});
      unique case (sym)
         cmq_pkg::SYM_FACE: begin
            vec[0] = q1;
            vec[1] = q2;
            vec[2] = q3;
         end
         cmq_pkg::SYM_EDGE: begin
            vec[0] = q1 - q2;
            vec[1] = q1 + q2;
            vec[2] = q3 - q4;
         end
         default: begin
            vec[0] = q1 - q2 + q3 - q4;
            vec[1] = q1 + q2 - q3 - q4;
            vec[2] = -q1 + q2 + q3 - q4;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      c_ff <= (cbest > CW'(ONE_P)) ? ONE_P : cbest[PW-1:0];
      for (int k = 0; k < 3; k++) begin
         v_ff[k] <= vec[k];
      end
   end

   // 1 - c^2 as (1 - c)(1 + c)
   logic [PW-1:0]     omc;
   logic [CW-1:0]     opc;
   logic [PW+CW-1:0]  nsq_full;
   logic [NW-1:0]     nsq_ff;
   logic [PW-1:0]     c2_ff;
   logic [2:0][VW-1:0] v2_ff;

   always_comb begin
      omc      = ONE_P - c_ff;
      opc      = CW'(ONE_P) + CW'(c_ff);
      nsq_full = (PW+CW)'(omc) * (PW+CW)'(opc);
   end

   always_ff @(posedge clock) begin
      nsq_ff <= nsq_full[NW-1:0];
      c2_ff  <= c_ff;
      v2_ff  <= v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[4:0], in_vld};
      end
   end

   assign out_vld = vld_ff[5];
   assign out_c   = c2_ff;
   assign out_v   = v2_ff;
   assign out_nsq = nsq_ff;

endmodule
